// ----- design/fpjs_pkg.sv -----
// Package: sizes, status codes and entry layout for the priority job scheduler.
`timescale 1ns / 1ps
`default_nettype none
package fpjs_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int NUM_LEVELS  = 4;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int LEVEL_W     = $clog2(NUM_LEVELS);
   localparam int ADDR_W      = $clog2(NUM_LEVELS * QUEUE_DEPTH);
   localparam int ENTRY_W     = 16;
   localparam int TIME_W      = 16;

   localparam logic [TIME_W-1:0] CUTOFF_RESET = 16'd100;
   localparam logic [TIME_W-1:0] TIME_MAX     = 16'hFFFF;
   localparam logic [7:0]        SERVED_MAX   = 8'hFF;

   // item operations
   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   // result status codes
   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_DROPPED  = 3'd1;
   localparam logic [2:0] ST_IDLE     = 3'd2;
   localparam logic [2:0] ST_RUNNING  = 3'd3;
   localparam logic [2:0] ST_FINISHED = 3'd4;
   localparam logic [2:0] ST_FLUSHED  = 3'd5;

   // one stored job: run length in the upper byte, id in the lower
   typedef struct packed {
      logic [7:0] run_length;
      logic [7:0] job_id;
   } entry_type;

   // next ring position of a queue pointer
   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + PTR_W'(1);
      return r;
   endfunction

   // flat memory address of a queue slot
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LEVEL_W-1:0] q,
                                                    input logic [PTR_W-1:0] p);
      return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
   endfunction

endpackage
`default_nettype wire

// ----- design/four_level_priority_job_scheduler.sv -----
// Top level: four-queue non-preemptive priority job scheduler.
//
//   channel | ports                        | handshake
//   --------+------------------------------+------------------------------
//   request | start, busy, req_*           | taken when start & !busy
//   result  | rsp_valid, rsp_*             | one-cycle strobe, no back-pressure
//   config  | csr_valid, csr_ready, csr_data | written when valid & ready
//
// One item per cycle; its result is registered and appears in the cycle after acceptance.
// busy is always low: the queue head of every level is held in a register,
// and a pop refills it from the job memory through its registered read port
// in the next cycle, forwarded when the same queue is popped again at once.
// Synchronous reset empties all queues, clears time and sets cutoff to 100.
// The receiver cannot stall; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module four_level_priority_job_scheduler (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_op,
   input  wire  [7:0]  req_job_id,
   input  wire  [2:0]  req_level,
   input  wire  [7:0]  req_run_length,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_run_id,
   output logic [2:0]  rsp_run_level,
   output logic [15:0] rsp_begin_tick,
   output logic [15:0] rsp_finish_tick,
   output logic [15:0] rsp_now_tick,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [15:0] csr_data
);

   localparam int NL = fpjs_pkg::NUM_LEVELS;

   // job memory and its registered read port
   fpjs_pkg::entry_type mem [0:NL*fpjs_pkg::QUEUE_DEPTH-1];
   fpjs_pkg::entry_type rd_data_ff;

   // queue control
   logic [fpjs_pkg::PTR_W-1:0]   head_ff [NL];
   logic [fpjs_pkg::PTR_W-1:0]   head_in [NL];
   logic [fpjs_pkg::PTR_W-1:0]   tail_ff [NL];
   logic [fpjs_pkg::PTR_W-1:0]   tail_in [NL];
   logic [fpjs_pkg::COUNT_W-1:0] count_ff [NL];
   logic [fpjs_pkg::COUNT_W-1:0] count_in [NL];
   fpjs_pkg::entry_type          cache_ff [NL];
   fpjs_pkg::entry_type          cache_in [NL];
   logic                         pend_ff, pend_in;
   logic [fpjs_pkg::LEVEL_W-1:0] pend_q_ff, pend_q_in;

   // running job
   logic                         running_ff, running_in;
   logic [7:0]                   cur_id_ff, cur_id_in;
   logic [fpjs_pkg::LEVEL_W-1:0] cur_q_ff, cur_q_in;
   logic [7:0]                   cur_req_ff, cur_req_in;
   logic [7:0]                   cur_served_ff, cur_served_in;
   logic [15:0]                  cur_begin_ff, cur_begin_in;
   logic [15:0]                  clock_count_ff, clock_count_in;
   logic [15:0]                  cutoff_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  run_id_ff, run_id_in;
   logic [2:0]  run_level_ff, run_level_in;
   logic [15:0] begin_ff, begin_in;
   logic [15:0] finish_ff, finish_in;
   logic [15:0] now_ff;

   // memory access requests
   logic                         wr_en;
   logic [fpjs_pkg::ADDR_W-1:0]  wr_addr;
   logic                         rd_en;
   logic [fpjs_pkg::ADDR_W-1:0]  rd_addr;

   logic                         accept;
   logic [fpjs_pkg::LEVEL_W-1:0] arr_q;
   logic [fpjs_pkg::LEVEL_W-1:0] pick_q;
   logic                         pick_any;
   fpjs_pkg::entry_type          head_val [NL];
   fpjs_pkg::entry_type          pick_entry;
   fpjs_pkg::entry_type          new_entry;
   logic [7:0]                   served_next;

   assign accept    = start && !busy;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign arr_q     = fpjs_pkg::LEVEL_W'(req_level - 3'd1);
   assign new_entry = '{run_length: req_run_length, job_id: req_job_id};

   // effective head of each queue, forwarding a refill still in flight
   always_comb begin
      for (int q = 0; q < NL; q++) begin
         if (pend_ff && pend_q_ff == fpjs_pkg::LEVEL_W'(q)) head_val[q] = rd_data_ff;
         else head_val[q] = cache_ff[q];
      end
   end

   // pick the lowest-numbered non-empty level
   always_comb begin
      pick_any = 1'b0;
      pick_q   = '0;
      for (int q = NL - 1; q >= 0; q--) begin
         if (count_ff[q] != '0) begin
            pick_any = 1'b1;
            pick_q   = fpjs_pkg::LEVEL_W'(q);
         end
      end
      pick_entry = head_val[pick_q];
   end

   // process one item
   always_comb begin
      for (int q = 0; q < NL; q++) begin
         head_in[q]  = head_ff[q];
         tail_in[q]  = tail_ff[q];
         count_in[q] = count_ff[q];
         cache_in[q] = cache_ff[q];
      end
      // land a pending refill
      if (pend_ff) cache_in[pend_q_ff] = rd_data_ff;
      pend_in        = 1'b0;
      pend_q_in      = pend_q_ff;
      running_in     = running_ff;
      cur_id_in      = cur_id_ff;
      cur_q_in       = cur_q_ff;
      cur_req_in     = cur_req_ff;
      cur_served_in  = cur_served_ff;
      cur_begin_in   = cur_begin_ff;
      clock_count_in = clock_count_ff;
      status_in      = status_ff;
      run_id_in      = run_id_ff;
      run_level_in   = run_level_ff;
      begin_in       = begin_ff;
      finish_in      = finish_ff;
      wr_en          = 1'b0;
      wr_addr        = fpjs_pkg::slot_addr(arr_q, tail_ff[arr_q]);
      rd_en          = 1'b0;
      rd_addr        = fpjs_pkg::slot_addr(pick_q, fpjs_pkg::next_slot(head_ff[pick_q]));
      served_next    = '0;

      if (accept) begin
         if (req_op == fpjs_pkg::OP_ARRIVAL) begin
            // enqueue or drop
            run_id_in    = req_job_id;
            run_level_in = req_level;
            begin_in     = '0;
            finish_in    = '0;
            if (req_level < 3'd1 || req_level > 3'(NL) ||
                count_ff[arr_q] >= fpjs_pkg::COUNT_W'(fpjs_pkg::QUEUE_DEPTH)) begin
               status_in = fpjs_pkg::ST_DROPPED;
            end else begin
               status_in       = fpjs_pkg::ST_ACCEPTED;
               wr_en           = 1'b1;
               tail_in[arr_q]  = fpjs_pkg::next_slot(tail_ff[arr_q]);
               count_in[arr_q] = count_ff[arr_q] + fpjs_pkg::COUNT_W'(1);
               if (count_ff[arr_q] == '0) cache_in[arr_q] = new_entry;
            end
         end else begin
            status_in    = fpjs_pkg::ST_IDLE;
            run_id_in    = '0;
            run_level_in = '0;
            begin_in     = '0;
            finish_in    = '0;
            if (!running_ff) begin
               if (clock_count_ff >= cutoff_ff) begin
                  // flush every queue
                  if (pick_any) status_in = fpjs_pkg::ST_FLUSHED;
                  for (int q = 0; q < NL; q++) begin
                     head_in[q]  = '0;
                     tail_in[q]  = '0;
                     count_in[q] = '0;
                  end
               end else if (pick_any) begin
                  // start the head job of the chosen level
                  head_in[pick_q]  = fpjs_pkg::next_slot(head_ff[pick_q]);
                  count_in[pick_q] = count_ff[pick_q] - fpjs_pkg::COUNT_W'(1);
                  if (count_ff[pick_q] > fpjs_pkg::COUNT_W'(1)) begin
                     rd_en     = 1'b1;
                     pend_in   = 1'b1;
                     pend_q_in = pick_q;
                  end
                  running_in    = 1'b1;
                  cur_id_in     = pick_entry.job_id;
                  cur_q_in      = pick_q;
                  cur_req_in    = pick_entry.run_length;
                  cur_served_in = '0;
                  cur_begin_in  = clock_count_ff;
               end
            end
            // serve the running job one tick
            if (running_in) begin
               served_next   = (cur_served_in < fpjs_pkg::SERVED_MAX) ?
                               cur_served_in + 8'd1 : cur_served_in;
               cur_served_in = served_next;
               run_id_in     = cur_id_in;
               run_level_in  = 3'(cur_q_in) + 3'd1;
               begin_in      = cur_begin_in;
               if (served_next >= cur_req_in) begin
                  status_in  = fpjs_pkg::ST_FINISHED;
                  finish_in  = clock_count_ff;
                  running_in = 1'b0;
               end else begin
                  status_in  = fpjs_pkg::ST_RUNNING;
               end
            end
            // advance time, saturating
            if (clock_count_ff < fpjs_pkg::TIME_MAX) clock_count_in = clock_count_ff + 16'd1;
         end
      end
   end

   // job memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= new_entry;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int q = 0; q < NL; q++) begin
            head_ff[q]  <= '0;
            tail_ff[q]  <= '0;
            count_ff[q] <= '0;
         end
         pend_ff        <= 1'b0;
         running_ff     <= 1'b0;
         cur_id_ff      <= '0;
         cur_q_ff       <= '0;
         cur_req_ff     <= '0;
         cur_served_ff  <= '0;
         cur_begin_ff   <= '0;
         clock_count_ff <= '0;
         cutoff_ff      <= fpjs_pkg::CUTOFF_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         for (int q = 0; q < NL; q++) begin
            head_ff[q]  <= head_in[q];
            tail_ff[q]  <= tail_in[q];
            count_ff[q] <= count_in[q];
         end
         pend_ff        <= pend_in;
         running_ff     <= running_in;
         cur_id_ff      <= cur_id_in;
         cur_q_ff       <= cur_q_in;
         cur_req_ff     <= cur_req_in;
         cur_served_ff  <= cur_served_in;
         cur_begin_ff   <= cur_begin_in;
         clock_count_ff <= clock_count_in;
         if (csr_valid && csr_ready) cutoff_ff <= csr_data;
         rsp_valid_ff   <= accept;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      for (int q = 0; q < NL; q++) cache_ff[q] <= cache_in[q];
      pend_q_ff    <= pend_q_in;
      status_ff    <= status_in;
      run_id_ff    <= run_id_in;
      run_level_ff <= run_level_in;
      begin_ff     <= begin_in;
      finish_ff    <= finish_in;
      if (accept) now_ff <= clock_count_ff;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_run_id      = run_id_ff;
   assign rsp_run_level   = run_level_ff;
   assign rsp_begin_tick  = begin_ff;
   assign rsp_finish_tick = finish_ff;
   assign rsp_now_tick    = now_ff;

endmodule
`default_nettype wire
